/* rtl/energy_zcr_voice_detector_assert.svh */
// Assertion macros for the energy and zero-crossing voice detector.
`ifndef ENERGY_ZCR_VOICE_DETECTOR_ASSERT_SVH
`define ENERGY_ZCR_VOICE_DETECTOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define EZVD_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define EZVD_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define EZVD_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define EZVD_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* rtl/ezvd_pkg.sv */
// Package with shared types and constants of the voice detector.
`timescale 1ns / 1ps
package ezvd_pkg;
  localparam int MAX_FRAME_DEF = 480;
  localparam int ENERGY_W = 40;
  localparam int THR_W = 15;
  localparam int FLEN_W = 9;
  localparam int SAMPLE_W = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [THR_W-1:0] THR_RESET = 15'd1147;
  localparam logic [THR_W-1:0] THR_FLOOR = 15'd33;
  localparam logic [FLEN_W-1:0] FLEN_RESET = 9'd320;
  localparam logic REG_THR = 1'b0;
  localparam logic REG_FLEN = 1'b1;

  typedef struct packed {
    logic [THR_W-1:0] rms_threshold;
    logic [FLEN_W-1:0] frame_length;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic square;
    logic accum;
    logic thr;
    logic prod;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic out_busy;
  } status_t;
endpackage

/* rtl/energy_zcr_voice_detector.sv */
// Top level of the energy and zero-crossing voice activity detector.
// Each accepted sample goes through acceptance, a squaring step in the 17 by 17 bit
// multiplier and an accumulation step; a new sample is taken only after the previous
// one has finished. After the last sample of a frame the sequencer forms the squared
// threshold, multiplies it by the frame length and makes the speech decision; that
// step waits while the previous speech flag is still not taken. One speech flag leaves
// per frame of frame_length samples (zero counts as one; capped at MAX_FRAME).
`timescale 1ns / 1ps
`include "energy_zcr_voice_detector_assert.svh"
module energy_zcr_voice_detector import ezvd_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_speech,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);
  cfg_t cfg;
  cmd_t cmd;
  status_t status;

  ezvd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ezvd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ezvd_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_sample  (in_sample),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_speech (out_speech)
  );

  `EZVD_ASSERT_NEXT(a_accept_then_square, clk, rst_n, in_valid && in_ready, cmd.square)
  `EZVD_ASSERT_IMPLIES(a_prod_after_thr, clk, rst_n, cmd.prod, $past(cmd.thr))
  `EZVD_ASSERT_IMPLIES(a_out_after_decide, clk, rst_n, $rose(out_valid), $past(cmd.decide))
  `EZVD_ASSERT_IMPLIES(a_no_decide_when_full, clk, rst_n, cmd.decide, !out_valid || out_ready)
endmodule

/* rtl/ezvd_regs.sv */
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module ezvd_regs import ezvd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);
  logic [THR_W-1:0] thr_r, thr_nxt;
  logic [FLEN_W-1:0] flen_r, flen_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    thr_nxt = thr_r;
    flen_nxt = flen_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_THR:  thr_nxt = pwdata[THR_W-1:0];
        REG_FLEN: flen_nxt = pwdata[FLEN_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      flen_r <= FLEN_RESET;
    end else begin
      thr_r <= thr_nxt;
      flen_r <= flen_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THR:  prdata = {{(APB_DATA_W-THR_W){1'b0}}, thr_r};
      REG_FLEN: prdata = {{(APB_DATA_W-FLEN_W){1'b0}}, flen_r};
      default:  prdata = '0;
    endcase
  end

  assign cfg.rms_threshold = thr_r;
  assign cfg.frame_length = flen_r;
endmodule

/* rtl/ezvd_ctrl.sv */
// Sequencer that steps the datapath through each sample and frame end.
`timescale 1ns / 1ps
module ezvd_ctrl import ezvd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_THR  = 3'd3;
  localparam logic [2:0] S_PROD = 3'd4;
  localparam logic [2:0] S_DEC  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = status.frame_end ? S_THR : S_IDLE;
      end
      S_THR: begin
        cmd.thr = 1'b1;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prod = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (!status.out_busy) begin
          cmd.decide = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

/* rtl/ezvd_dp.sv */
// Datapath with the energy and crossing accumulators and the frame decision.
`timescale 1ns / 1ps
module ezvd_dp import ezvd_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  cfg_t                cfg,
  input  cmd_t                cmd,
  output status_t             status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_speech
);
  localparam int MAXLEN = (MAX_FRAME < 511) ? MAX_FRAME : 511;
  localparam int LEN_W = $clog2(MAXLEN + 1);

  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W:0] mag;
  logic [2*SAMPLE_W+1:0] sq_full;
  logic [2*SAMPLE_W-2:0] sq_r;
  logic [ENERGY_W-1:0] energy_r;
  logic [LEN_W-1:0] cc_r, idx_r, len, span;
  logic prev_r;
  logic [THR_W-1:0] thr_eff;
  logic [2*THR_W-1:0] thr2_full, thr2_r;
  logic [ENERGY_W-1:0] lim_full, lim_r;
  logic out_valid_r, speech_r;
  logic loud, rate_ok;

  always_comb begin
    if (cfg.frame_length == '0) begin
      len = LEN_W'(1);
    end else if (32'(cfg.frame_length) > MAXLEN) begin
      len = LEN_W'(MAXLEN);
    end else begin
      len = LEN_W'(cfg.frame_length);
    end
  end

  assign span = len - LEN_W'(1);
  assign thr_eff = (cfg.rms_threshold < THR_FLOOR) ? THR_FLOOR : cfg.rms_threshold;
  assign mag = sample_r[SAMPLE_W-1] ? ((SAMPLE_W+1)'(1) << SAMPLE_W) - {1'b0, sample_r}
                                    : {1'b0, sample_r};
  assign sq_full = mag * mag;
  assign thr2_full = thr_eff * thr_eff;
  assign lim_full = ENERGY_W'(thr2_r) * ENERGY_W'(len);

  assign loud = (energy_r >= lim_r);
  assign rate_ok = (16'(cc_r) * 16'd100 >= 16'(span)) &&
                   (({2'b00, cc_r} << 2) <= {2'b00, span}) &&
                   (len > LEN_W'(1));

  assign status.frame_end = (idx_r >= len);
  assign status.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
    end
    if (cmd.square) begin
      sq_r <= sq_full[2*SAMPLE_W-2:0];
    end
    if (cmd.thr) begin
      thr2_r <= thr2_full;
    end
    if (cmd.prod) begin
      lim_r <= lim_full;
    end
    if (cmd.decide) begin
      speech_r <= loud && rate_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r <= '0;
      cc_r <= '0;
      idx_r <= '0;
      prev_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.square) begin
        if (idx_r != '0 && sample_r[SAMPLE_W-1] != prev_r) begin
          cc_r <= cc_r + LEN_W'(1);
        end
        prev_r <= sample_r[SAMPLE_W-1];
        idx_r <= idx_r + LEN_W'(1);
      end
      if (cmd.accum) begin
        energy_r <= energy_r + ENERGY_W'(sq_r);
      end
      if (cmd.decide) begin
        energy_r <= '0;
        cc_r <= '0;
        idx_r <= '0;
        prev_r <= 1'b0;
      end
      if (cmd.decide) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_speech = speech_r;
endmodule

/* bench/tb_energy_zcr_voice_detector.sv */
// Self-checking testbench for the energy and zero-crossing voice detector.
`timescale 1ns / 1ps
module tb_energy_zcr_voice_detector;
  import ezvd_pkg::*;

  typedef enum int {FR_VOICED, FR_NOISE, FR_QUIET, FR_ALTERNATE, FR_FLAT} frame_kind_e;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int ITEM_TARGET = 1500;
  localparam int FLAG_TARGET = 48;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [APB_ADDR_W-1:0] ADDR_THR = APB_ADDR_W'({REG_THR, 2'b00});
  localparam logic [APB_ADDR_W-1:0] ADDR_FLEN = APB_ADDR_W'({REG_FLEN, 2'b00});

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_speech;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  logic [THR_W-1:0] m_thr = THR_RESET;
  logic [FLEN_W-1:0] m_flen = FLEN_RESET;
  logic [ENERGY_W-1:0] m_energy = '0;
  logic [FLEN_W-1:0] m_crossings = '0;
  logic [FLEN_W-1:0] m_index = '0;
  logic m_prev_neg = 1'b0;

  logic [SAMPLE_W-1:0] pending_samples[$];
  bit expected_flags[$];

  int samples_sent = 0;
  int flags_checked = 0;
  int speech_flags = 0;
  int mismatches = 0;
  int settings_used = 0;
  int cycle_count = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  bit in_taken = 1'b0;

  int thr_picks[8] = '{0, 32, 33, 819, 983, 1147, 1475, 32767};
  int flen_picks[9] = '{0, 1, 2, 5, 160, 320, 480, 481, 511};
  int directed_frames[20] = '{
    1147, 1147, -1147, -1147, -1147,
    1146, 1146, -1146, -1146, -1146,
    0, -1, 0, 0, 0,
    -32768, -32768, -32768, 32767, 32767
  };

  energy_zcr_voice_detector dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_speech(out_speech),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_length(input logic [FLEN_W-1:0] f);
    if (f == 0) return 1;
    if (f > MAX_FRAME_DEF) return MAX_FRAME_DEF;
    return f;
  endfunction

  function automatic int unsigned eff_threshold(input logic [THR_W-1:0] t);
    return (t < THR_FLOOR) ? THR_FLOOR : t;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Advances the frame accumulators by one sample; returns 1 when the sample closes a frame.
  function automatic bit frame_step(input logic [SAMPLE_W-1:0] s, output bit speech);
    logic neg;
    logic [16:0] mag;
    logic [33:0] sq;
    longint unsigned limit;
    int unsigned len, thr, span, cc;
    neg = s[SAMPLE_W-1];
    mag = neg ? (17'h10000 - {1'b0, s}) : {1'b0, s};
    sq = mag * mag;
    len = eff_length(m_flen);
    m_energy = m_energy + ENERGY_W'(sq);
    if (m_index != 0 && neg != m_prev_neg) m_crossings = m_crossings + 1'b1;
    m_prev_neg = neg;
    m_index = m_index + 1'b1;
    speech = 1'b0;
    if (m_index < len) return 1'b0;
    thr = eff_threshold(m_thr);
    limit = longint'(thr) * longint'(thr) * longint'(len);
    span = len - 1;
    cc = m_crossings;
    speech = (m_energy >= limit) && (100 * cc >= span) && (4 * cc <= span) && (len > 1);
    m_energy = '0;
    m_crossings = '0;
    m_index = '0;
    m_prev_neg = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    bit flag;
    in_taken = 1'b0;
    if (!rst_n) begin
      m_thr = THR_RESET;
      m_flen = FLEN_RESET;
      m_energy = '0;
      m_crossings = '0;
      m_index = '0;
      m_prev_neg = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_flags.size() == 0) begin
          $error("speech: no transaction expected, got %0b", out_speech);
          mismatches++;
        end else begin
          flag = expected_flags.pop_front();
          if (out_speech !== flag) begin
            $error("speech: expected %0b, got %0b", flag, out_speech);
            mismatches++;
          end
          flags_checked++;
          speech_flags += int'(flag);
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        if (frame_step(in_sample, flag)) expected_flags.push_back(flag);
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_THR) m_thr = pwdata[THR_W-1:0];
        else if (paddr == ADDR_FLEN) m_flen = pwdata[FLEN_W-1:0];
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        in_valid <= 1'b1;
        in_sample <= pending_samples.pop_front();
        in_gap = in_idle_on ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_stall > 0) out_stall--;
    else if (out_idle_on && $urandom_range(0, 3) == 0) out_stall = pick_gap();
    out_ready <= rst_n && (out_stall == 0);
  end

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input int thr, input int flen);
    apb_write(ADDR_THR, APB_DATA_W'(thr));
    apb_write(ADDR_FLEN, APB_DATA_W'(flen));
    settings_used++;
  endtask

  // The short delay lets the driver's updates at the falling edge settle before the check.
  task automatic wait_idle();
    do begin
      @(negedge clk);
      #1;
    end while (pending_samples.size() != 0 || in_valid || expected_flags.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_value(input int v);
    pending_samples.push_back(SAMPLE_W'(v));
    samples_sent++;
  endtask

  task automatic push_frame(input frame_kind_e kind, input int n, input int thr);
    int amp, mag, flip_pct;
    bit neg;
    amp = thr * int'($urandom_range(70, 160)) / 100;
    if (amp > 32767) amp = 32767;
    if (amp < 1) amp = 1;
    flip_pct = $urandom_range(0, 30);
    neg = $urandom_range(0, 1);
    for (int k = 0; k < n; k++) begin
      case (kind)
        FR_VOICED: begin
          if (k != 0 && int'($urandom_range(0, 99)) < flip_pct) neg = !neg;
          mag = amp + int'($urandom_range(0, amp / 16)) - amp / 32;
          if (mag > 32767) mag = 32767;
          if (mag < 0) mag = 0;
          push_value(neg ? -mag : mag);
        end
        FR_NOISE: push_value(int'($urandom_range(0, 16'hFFFF)));
        FR_QUIET: begin
          mag = $urandom_range(0, thr / 2);
          push_value($urandom_range(0, 1) ? -mag : mag);
        end
        FR_ALTERNATE: begin
          neg = !neg;
          push_value(neg ? -amp : amp);
        end
        default: push_value(neg ? -amp : amp);
      endcase
    end
  endtask

  initial begin
    int thr, flen, len, nframes, r, phase;
    frame_kind_e kind;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Default register values straight out of reset.
    push_frame(FR_VOICED, 320, 1147);
    push_frame(FR_VOICED, 320, 1147);
    wait_idle();

    // Energy and crossing boundaries with five-sample frames.
    configure(1147, 5);
    foreach (directed_frames[i]) push_value(directed_frames[i]);
    wait_idle();
    // Threshold below the floor and a zero frame length.
    configure(0, 0);
    push_value(32767);
    push_value(-32768);
    push_value(0);
    wait_idle();
    // A two-sample frame never passes the rate test.
    configure(33, 2);
    push_value(33);
    push_value(-33);
    wait_idle();
    // Shorten the frame while three samples are already taken.
    configure(33, 9);
    push_value(4000);
    push_value(-4000);
    push_value(4000);
    wait_idle();
    configure(33, 2);
    push_value(4000);
    wait_idle();

    phase = 0;
    while ((samples_sent < ITEM_TARGET || flags_checked < FLAG_TARGET) && phase < 300) begin
      r = $urandom_range(0, 9);
      if (r < 2) thr = thr_picks[$urandom_range(0, 7)];
      else if (r < 3) thr = $urandom_range(0, 32767);
      else thr = $urandom_range(200, 6000);
      r = $urandom_range(0, 9);
      if (r < 2) flen = flen_picks[$urandom_range(0, 8)];
      else if (r < 3) flen = $urandom_range(65, 300);
      else flen = $urandom_range(2, 64);
      configure(thr, flen);
      in_idle_on = $urandom_range(0, 3) != 0;
      out_idle_on = $urandom_range(0, 3) != 0;
      len = eff_length(FLEN_W'(flen));
      nframes = (len >= 100) ? $urandom_range(1, 2) : 1 + 120 / len;
      for (int f = 0; f < nframes; f++) begin
        r = $urandom_range(0, 99);
        if (r < 60) kind = FR_VOICED;
        else if (r < 72) kind = FR_NOISE;
        else if (r < 82) kind = FR_QUIET;
        else if (r < 92) kind = FR_ALTERNATE;
        else kind = FR_FLAT;
        push_frame(kind, len, eff_threshold(THR_W'(thr)));
      end
      if ($urandom_range(0, 3) == 0)
        push_frame(FR_VOICED, $urandom_range(1, len), eff_threshold(THR_W'(thr)));
      wait_idle();
      phase++;
    end

    wait_idle();
    if (expected_flags.size() != 0) begin
      $error("speech: %0d expected transactions never arrived", expected_flags.size());
      mismatches++;
    end
    $display("Sent %0d samples under %0d register settings.", samples_sent, settings_used);
    $display("Checked %0d frame flags, %0d of them speech.", flags_checked, speech_flags);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
